>>> sv/tgarle_pkg.sv
// tgarle_pkg: shared types and constants of the tga run-length pixel decoder
// used by tgarle_front, tgarle_back and tga_rle_pixel_decoder_core; no dependencies
`default_nettype none

package tgarle_pkg;

	localparam int PIXEL_COUNT_BITS = 24;
	localparam int QUEUE_DEPTH      = 2;
	localparam int QUEUE_PTR_BITS   = $clog2(QUEUE_DEPTH);
	localparam int QUEUE_CNT_BITS   = $clog2(QUEUE_DEPTH + 1);

	localparam int PKT_RUN_BIT      = 7;

	localparam logic [1:0] REG_BYTES_PER_PIXEL  = 2'd0;
	localparam logic [1:0] REG_RUN_LENGTH_CODED = 2'd1;
	localparam logic [1:0] REG_TOTAL_PIXELS     = 2'd2;

	localparam logic [2:0] BPP_RESET            = 3'd4;
	localparam logic [2:0] BPP_RGB              = 3'd3;

	typedef logic [PIXEL_COUNT_BITS-1:0] pix_count_t;

	typedef struct packed {
		logic       first_byte;
		logic [7:0] data_byte;
	} byte_item_t;

	typedef struct packed {
		logic [2:0] bytes_per_pixel;
		logic       run_length_coded;
		pix_count_t total_pixels;
	} cfg_t;

	typedef struct packed {
		logic [31:0] pixel_value;
		logic [7:0]  repeat_count;
		logic        image_done;
		logic        overrun;
	} result_t;

endpackage

`default_nettype wire

>>> sv/tga_rle_pixel_decoder_core.sv
// tga_rle_pixel_decoder_core: top level of the tga run-length pixel decoder
// holds the configuration registers; depends on tgarle_pkg, tgarle_front, tgarle_back
//
// channel  direction  signals                         item
// s_*      in         tvalid tready tdata[7:0] tuser  one image data byte
// m_*      out        tvalid tready tdata[39:0] tlast tuser  one pixel result
// cfg_*    in         valid ready index[1:0] data[23:0]     one register write
//
// a new byte is taken every cycle while the result register drains or is empty,
// so the rate is one byte per cycle
// a stalled result holds the back end; the two-entry byte queue takes two more items,
// then s_tready drops until the result leaves
// reset clears the decoder state and loads 4 bytes per pixel, run-length mode, total 1
// cfg_ready is always high; a write to index 3 is taken and ignored
`default_nettype none

module tga_rle_pixel_decoder_core
	import tgarle_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,   // data_byte
	input  wire logic        s_tuser,   // first_byte
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [39:0]      m_tdata,   // pixel_value[31:0], repeat_count[39:32]
	output logic             m_tlast,   // image_done
	output logic             m_tuser,   // overrun
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [23:0] cfg_data
);

	cfg_t       cfg_q;
	byte_item_t in_item;
	byte_item_t q_item;
	logic       q_valid;
	logic       q_pop;
	result_t    result;

	assign cfg_ready          = 1'b1;
	assign in_item.data_byte  = s_tdata;
	assign in_item.first_byte = s_tuser;
	assign m_tdata            = {result.repeat_count, result.pixel_value};
	assign m_tlast            = result.image_done;
	assign m_tuser            = result.overrun;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.bytes_per_pixel  <= BPP_RESET;
			cfg_q.run_length_coded <= 1'b1;
			cfg_q.total_pixels     <= pix_count_t'(1);
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_BYTES_PER_PIXEL:  cfg_q.bytes_per_pixel  <= cfg_data[2:0];
				REG_RUN_LENGTH_CODED: cfg_q.run_length_coded <= cfg_data[0];
				REG_TOTAL_PIXELS:     cfg_q.total_pixels     <= pix_count_t'(cfg_data);
				default: ;
			endcase
		end
	end

	tgarle_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.in_item  (in_item),
		.q_valid  (q_valid),
		.q_pop    (q_pop),
		.q_item   (q_item)
	);

	tgarle_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.q_valid    (q_valid),
		.q_pop      (q_pop),
		.q_item     (q_item),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_result (result)
	);

endmodule

`default_nettype wire

>>> sv/tgarle_front.sv
// tgarle_front: input side of the decoder, a small byte queue in front of the back end
// depends on tgarle_pkg
`default_nettype none

module tgarle_front
	import tgarle_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire byte_item_t in_item,
	output logic            q_valid,
	input  wire logic       q_pop,
	output byte_item_t      q_item
);

	byte_item_t                mem_q [QUEUE_DEPTH];
	logic [QUEUE_PTR_BITS-1:0] wr_ptr_q;
	logic [QUEUE_PTR_BITS-1:0] rd_ptr_q;
	logic [QUEUE_CNT_BITS-1:0] cnt_q;
	logic                      push;
	logic                      pop;

	assign in_ready = (cnt_q != QUEUE_CNT_BITS'(QUEUE_DEPTH));
	assign q_valid  = (cnt_q != '0);
	assign q_item   = mem_q[rd_ptr_q];
	assign push     = in_valid && in_ready;
	assign pop      = q_pop && q_valid;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= in_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QUEUE_PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QUEUE_PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

>>> sv/tgarle_back.sv
// tgarle_back: packet decode, pixel assembly, pixel counting and the result register
// depends on tgarle_pkg
`default_nettype none

module tgarle_back
	import tgarle_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire cfg_t       cfg,
	input  wire logic       q_valid,
	output logic            q_pop,
	input  wire byte_item_t q_item,
	output logic            out_valid,
	input  wire logic       out_ready,
	output result_t         out_result
);

	logic        awaiting_q;
	logic        is_run_q;
	logic [7:0]  pkt_left_q;
	logic [1:0]  bip_q;
	logic [31:0] acc_q;
	pix_count_t  emitted_q;
	logic        finished_q;
	logic        out_valid_q;
	result_t     result_q;

	logic        advance;
	logic        clr;
	logic        aw, is_run, fin;
	logic [7:0]  pkt_left;
	logic [1:0]  bip;
	logic [31:0] acc;
	pix_count_t  emitted;

	logic        aw_d, is_run_d, fin_d;
	logic [7:0]  pkt_left_d;
	logic [1:0]  bip_d;
	logic [31:0] acc_d;
	pix_count_t  emitted_d;
	logic        emit;
	result_t     result_d;

	logic        size4, rle, image_idle, complete, run_over, reach_total;
	logic [2:0]  bip_inc;
	logic [31:0] acc_new;
	pix_count_t  remaining;
	pix_count_t  count_wide;
	logic [7:0]  count_raw;
	logic [7:0]  count_final;
	logic [7:0]  pkt_dec;

	assign advance   = q_valid && (!out_valid_q || out_ready);
	assign q_pop     = advance;
	assign out_valid = out_valid_q;
	assign out_result = result_q;

	always_comb begin
		clr      = q_item.first_byte;
		aw       = clr ? 1'b1 : awaiting_q;
		is_run   = clr ? 1'b0 : is_run_q;
		pkt_left = clr ? 8'd0 : pkt_left_q;
		bip      = clr ? 2'd0 : bip_q;
		acc      = clr ? 32'd0 : acc_q;
		emitted  = clr ? '0 : emitted_q;
		fin      = clr ? 1'b0 : finished_q;

		size4       = (cfg.bytes_per_pixel != BPP_RGB);
		rle         = cfg.run_length_coded;
		image_idle  = fin || (emitted >= cfg.total_pixels);
		remaining   = cfg.total_pixels - emitted;
		acc_new     = acc | (32'(q_item.data_byte) << {bip, 3'b000});
		bip_inc     = {1'b0, bip} + 3'd1;
		complete    = bip_inc >= (size4 ? 3'd4 : 3'd3);
		pkt_dec     = (pkt_left == 8'd0) ? 8'd0 : pkt_left - 8'd1;
		count_raw   = (rle && is_run && (pkt_left != 8'd0)) ? pkt_left : 8'd1;
		count_wide  = pix_count_t'(count_raw);
		run_over    = count_wide > remaining;
		reach_total = count_wide >= remaining;
		count_final = (rle && is_run && run_over) ? remaining[7:0] : count_raw;

		aw_d       = aw;
		is_run_d   = is_run;
		pkt_left_d = pkt_left;
		bip_d      = bip;
		acc_d      = acc;
		emitted_d  = emitted;
		fin_d      = fin;
		emit       = 1'b0;
		result_d.pixel_value  = acc_new;
		result_d.repeat_count = count_final;
		result_d.image_done   = reach_total;
		result_d.overrun      = 1'b0;

		if (image_idle) begin
			// byte ignored
		end else if (rle && aw) begin
			is_run_d   = q_item.data_byte[PKT_RUN_BIT];
			pkt_left_d = {1'b0, q_item.data_byte[6:0]} + 8'd1;
			aw_d       = 1'b0;
			bip_d      = 2'd0;
			acc_d      = 32'd0;
		end else if (!complete) begin
			acc_d = acc_new;
			bip_d = bip_inc[1:0];
		end else begin
			acc_d     = 32'd0;
			bip_d     = 2'd0;
			emit      = 1'b1;
			emitted_d = emitted + pix_count_t'(count_final);
			fin_d     = reach_total;
			if (rle && is_run) begin
				pkt_left_d       = 8'd0;
				aw_d             = 1'b1;
				result_d.overrun = run_over;
			end else if (rle) begin
				pkt_left_d       = pkt_dec;
				aw_d             = (pkt_dec == 8'd0);
				result_d.overrun = (remaining == pix_count_t'(1)) && (pkt_dec != 8'd0);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			awaiting_q  <= 1'b1;
			is_run_q    <= 1'b0;
			pkt_left_q  <= 8'd0;
			bip_q       <= 2'd0;
			acc_q       <= 32'd0;
			emitted_q   <= '0;
			finished_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				awaiting_q <= aw_d;
				is_run_q   <= is_run_d;
				pkt_left_q <= pkt_left_d;
				bip_q      <= bip_d;
				acc_q      <= acc_d;
				emitted_q  <= emitted_d;
				finished_q <= fin_d;
			end
			if (advance && emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && emit) begin
			result_q <= result_d;
		end
	end

endmodule

`default_nettype wire
